/* rtl/rip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_pkg
// Types and constants shared by the radix integer parser modules.
// ----------------------------------------------------------------------------
package rip_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned BASE_W  = 6;
   localparam int unsigned VALUE_W = 64;
   // magnitude * base + digit before the limit check
   localparam int unsigned PROD_W  = VALUE_W + BASE_W;

   localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_DIGIT_LO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_DIGIT_HI   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_LO   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_HI   = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_LO   = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_HI   = 8'h7A;

   // largest positive magnitude, 2^63-1
   localparam logic [VALUE_W-1:0] LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [VALUE_W-1:0] magnitude;
      logic               neg_sign;
      logic               seen_first;
      logic               has_body;
      logic               stopped;
      logic               overflowed;
   } tok_state_type;

endpackage
`default_nettype wire

/* rtl/rip_digit_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_digit_step
// Folds one character into the token state and forms the result on the
// final character of a token.
// ----------------------------------------------------------------------------
module rip_digit_step (
   input  rip_pkg::tok_state_type        cur_state,
   input  logic [rip_pkg::CHAR_W-1:0]    char_in,
   input  logic [rip_pkg::BASE_W-1:0]    base,
   input  logic                          last_char,
   input  logic                          skip_underscores,
   output rip_pkg::tok_state_type        nxt_state,
   output logic signed [rip_pkg::VALUE_W-1:0] value,
   output logic                          ok
);
   import rip_pkg::*;

   logic [BASE_W-1:0]  digit;
   logic               is_digit;
   logic               take_body;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  limit;

   // digit value of the character
   always_comb begin
      digit    = '0;
      is_digit = 1'b0;
      if (char_in >= CH_DIGIT_LO && char_in <= CH_DIGIT_HI) begin
         digit    = BASE_W'(char_in - CH_DIGIT_LO);
         is_digit = 1'b1;
      end else if (char_in >= CH_UPPER_LO && char_in <= CH_UPPER_HI) begin
         digit    = BASE_W'(char_in - CH_UPPER_LO) + BASE_W'(10);
         is_digit = 1'b1;
      end else if (char_in >= CH_LOWER_LO && char_in <= CH_LOWER_HI) begin
         digit    = BASE_W'(char_in - CH_LOWER_LO) + BASE_W'(10);
         is_digit = 1'b1;
      end
   end

   assign prod  = PROD_W'(cur_state.magnitude) * PROD_W'(base) + PROD_W'(digit);
   assign limit = PROD_W'(LIMIT_POS) + PROD_W'(cur_state.neg_sign);

   always_comb begin
      nxt_state = cur_state;
      value     = '0;
      ok        = 1'b0;
      take_body = 1'b1;

      // leading sign
      if (!cur_state.seen_first) begin
         nxt_state.seen_first = 1'b1;
         if (char_in == CH_MINUS) begin
            nxt_state.neg_sign = 1'b1;
            take_body          = 1'b0;
         end else if (char_in == CH_PLUS) begin
            take_body = 1'b0;
         end
      end

      if (take_body) begin
         nxt_state.has_body = 1'b1;
         if (!cur_state.stopped && !cur_state.overflowed &&
             !(char_in == CH_UNDERSCORE && skip_underscores)) begin
            if (!is_digit || digit >= base) begin
               nxt_state.stopped = 1'b1;
            end else if (prod > limit) begin
               nxt_state.overflowed = 1'b1;
            end else begin
               nxt_state.magnitude = prod[VALUE_W-1:0];
            end
         end
      end

      // end of token
      if (last_char) begin
         ok = nxt_state.has_body && !nxt_state.overflowed;
         if (ok) begin
            value = nxt_state.neg_sign ? (~nxt_state.magnitude + VALUE_W'(1))
                                       : nxt_state.magnitude;
         end
         nxt_state = '0;
      end
   end

endmodule
`default_nettype wire

/* rtl/radix_int64_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_int64_parser
// Streaming signed 64-bit integer parser with a radix of 2 to 36.
// ----------------------------------------------------------------------------
// One character item is accepted per clock, with no gaps between tokens,
// unless a final item waits on a stalled result. Each item is captured in
// an input register and folded into the token state; the item with
// req_last_char set loads its result into the output register as it is
// folded, and the result is held there until taken. The clock rate is
// set by the 64x6 multiply-add and the limit compare in rip_digit_step.
// A stalled result holds back only a following final character; earlier
// characters keep flowing, later ones wait. There is no clearing pass
// after reset. csr_wr_data sets the skip-underscore mode and must be
// written only while no token is in flight; the block does not check it.
module radix_int64_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rip_pkg::CHAR_W-1:0]         req_char_in,
   input  logic [rip_pkg::BASE_W-1:0]         req_base,
   input  logic                               req_last_char,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [rip_pkg::VALUE_W-1:0] rsp_value,
   output logic                               rsp_ok,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data
);
   import rip_pkg::*;

   logic                       skip_ff;
   logic                       s1_vld_ff, s1_vld_in;
   logic [CHAR_W-1:0]          s1_char_ff;
   logic [BASE_W-1:0]          s1_base_ff;
   logic                       s1_last_ff;
   tok_state_type              tok_ff, tok_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic                       s1_adv;
   logic                       req_take;

   rip_digit_step u_step (
      .cur_state        (tok_ff),
      .char_in          (s1_char_ff),
      .base             (s1_base_ff),
      .last_char        (s1_last_ff),
      .skip_underscores (skip_ff),
      .nxt_state        (tok_in),
      .value            (rsp_value_in),
      .ok               (rsp_ok_in)
   );

   // non-final items never wait on the output side
   assign s1_adv       = s1_vld_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_vld_ff || s1_adv;
   assign req_take     = req_valid && req_ready;
   assign s1_vld_in    = req_take || (s1_vld_ff && !s1_adv);
   assign rsp_valid_in = (s1_adv && s1_last_ff) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff      <= 1'b0;
         s1_vld_ff    <= 1'b0;
         tok_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            skip_ff <= csr_wr_data;
         end
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            tok_ff <= tok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_char_in;
         s1_base_ff <= req_base;
         s1_last_ff <= req_last_char;
      end
      if (s1_adv && s1_last_ff) begin
         rsp_value_ff <= rsp_value_in;
         rsp_ok_ff    <= rsp_ok_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_ok    = rsp_ok_ff;

endmodule
`default_nettype wire

/* rtl/rip_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_checker
// Port-level checks for the radix integer parser.
// ----------------------------------------------------------------------------
module rip_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [rip_pkg::CHAR_W-1:0]         req_char_in,
   input  logic [rip_pkg::BASE_W-1:0]         req_base,
   input  logic                               req_last_char,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [rip_pkg::VALUE_W-1:0] rsp_value,
   input  logic                               rsp_ok
);
   import rip_pkg::*;

   // a waiting item holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_char_in) &&
                                  $stable(req_base) && $stable(req_last_char))
      else $error("waiting item changed");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_ok))
      else $error("stalled result changed");

   // failed parse reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_value == '0)
      else $error("failed parse with nonzero value");

   // a fresh result follows an accepted final item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_char, 2))
      else $error("result without a final item");

   // output is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind radix_int64_parser rip_checker u_rip_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_char_in   (req_char_in),
   .req_base      (req_base),
   .req_last_char (req_last_char),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_value     (rsp_value),
   .rsp_ok        (rsp_ok)
);
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radix_int64_parser. Tokens are streamed one
// character per item with bursty valid and a stalling receiver. A local
// accumulator predicts value and ok for each token and every result is
// compared in order. Directed tokens cover signs, field extremes and the
// underscore mode; random tokens cover numbers near the 64-bit limits,
// trailing garbage, raw noise and sign-led forms in radix 2 to 36.
// ----------------------------------------------------------------------------
module tb;
   import rip_pkg::*;

   localparam int STUCK_LIMIT = 4000;
   localparam int DRAIN_TAIL  = 4;
   localparam int unsigned NOT_DIGIT = 255;
   localparam logic [VALUE_W-1:0] LIMIT_NEG = LIMIT_POS + 64'd1;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      ok;
   } parse_result_type;

   typedef enum int {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_type;
   typedef enum int {SIGN_NONE, SIGN_MINUS, SIGN_PLUS} sign_kind_type;
   typedef enum int {TOK_NUMBER, TOK_NEAR_LIMIT, TOK_TRAILING, TOK_NOISE,
                     TOK_SIGNS} token_kind_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [CHAR_W-1:0]         req_char_in = '0;
   logic [BASE_W-1:0]         req_base = 6'd10;
   logic                      req_last_char = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value;
   logic                      rsp_ok;
   logic                      csr_wr_en = 1'b0;
   logic                      csr_wr_data = 1'b0;

   // predicted token state
   logic [VALUE_W-1:0] acc_mag = '0;
   logic acc_neg = 1'b0;
   logic acc_started = 1'b0;
   logic acc_body = 1'b0;
   logic acc_halted = 1'b0;
   logic acc_ovf = 1'b0;
   logic skip_us_cfg = 1'b0;

   parse_result_type pending_results[$];
   parse_result_type want;
   logic [CHAR_W-1:0] token_chars[$];

   int chars_sent = 0;
   int tokens_sent = 0;
   int results_checked = 0;
   int rejected_count = 0;
   int negative_count = 0;
   int fail_count = 0;
   int burst_left = 0;
   int rx_left = 0;
   rx_mode_type rx_mode = RX_OPEN;

   radix_int64_parser u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_in   (req_char_in),
      .req_base      (req_base),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_ok        (rsp_ok),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic int unsigned char_weight(input logic [CHAR_W-1:0] c);
      if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) return c - CH_DIGIT_LO;
      if (c >= CH_UPPER_LO && c <= CH_UPPER_HI) return c - CH_UPPER_LO + 10;
      if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) return c - CH_LOWER_LO + 10;
      return NOT_DIGIT;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
      if (d < 10) return CH_DIGIT_LO + 8'(d);
      if ($urandom_range(0, 1) == 1) return CH_UPPER_LO + 8'(d - 10);
      return CH_LOWER_LO + 8'(d - 10);
   endfunction

   // fold one accepted character into the token, queue the result on the last one
   function automatic void fold_char(input logic [CHAR_W-1:0] ch, input logic [BASE_W-1:0] b,
                                     input logic last);
      logic [VALUE_W-1:0] rad, lim, cut, rem;
      int unsigned d;
      parse_result_type res;
      rad = 64'(b);
      d = char_weight(ch);
      if (!acc_started && (ch == CH_MINUS || ch == CH_PLUS)) begin
         acc_neg = (ch == CH_MINUS);
      end else begin
         acc_body = 1'b1;
         if (!(acc_halted || acc_ovf || (ch == CH_UNDERSCORE && skip_us_cfg))) begin
            if (d >= b) begin
               acc_halted = 1'b1;
            end else begin
               lim = acc_neg ? LIMIT_NEG : LIMIT_POS;
               cut = lim / rad;
               rem = lim % rad;
               if (acc_mag > cut || (acc_mag == cut && 64'(d) > rem)) acc_ovf = 1'b1;
               else acc_mag = acc_mag * rad + 64'(d);
            end
         end
      end
      acc_started = 1'b1;
      if (last) begin
         res.ok = acc_body && !acc_ovf;
         res.value = !res.ok ? '0 : acc_neg ? 64'd0 - acc_mag : acc_mag;
         pending_results.push_back(res);
         if (!res.ok) rejected_count++;
         if (res.value < 0) negative_count++;
         acc_mag = '0;
         acc_neg = 1'b0;
         acc_started = 1'b0;
         acc_body = 1'b0;
         acc_halted = 1'b0;
         acc_ovf = 1'b0;
      end
   endfunction

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic [BASE_W-1:0] b,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_char_in <= ch;
      req_base <= b;
      req_last_char <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      fold_char(ch, b, last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_token(input logic [BASE_W-1:0] b);
      for (int i = 0; i < token_chars.size(); i++) begin
         send_char(token_chars[i], b, i == token_chars.size() - 1);
      end
      token_chars.delete();
      tokens_sent++;
   endtask

   // hold the sender until every queued result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_TAIL) @(negedge clock);
   endtask

   task automatic set_underscore_skip(input logic en);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= en;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      skip_us_cfg = en;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         token_chars.push_back(s[i]);
      end
   endtask

   task automatic put_sign(input sign_kind_type s);
      if (s == SIGN_MINUS) token_chars.push_back(CH_MINUS);
      else if (s == SIGN_PLUS) token_chars.push_back(CH_PLUS);
   endtask

   task automatic put_digits(input logic [BASE_W-1:0] b, input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) token_chars.push_back(CH_UNDERSCORE);
         token_chars.push_back(digit_char($urandom_range(0, b - 1)));
      end
   endtask

   task automatic put_magnitude(input logic [VALUE_W-1:0] m, input logic [BASE_W-1:0] b);
      logic [CHAR_W-1:0] rev[$];
      do begin
         rev.push_front(digit_char(int'(m % 64'(b))));
         m = m / 64'(b);
      end while (m != 0);
      foreach (rev[i]) token_chars.push_back(rev[i]);
   endtask

   task automatic put_non_digit(input logic [BASE_W-1:0] b);
      logic [CHAR_W-1:0] c;
      do c = 8'($urandom_range(0, 255)); while (char_weight(c) < b);
      token_chars.push_back(c);
   endtask

   function automatic token_kind_type pick_kind();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 45) return TOK_NUMBER;
      if (p < 60) return TOK_NEAR_LIMIT;
      if (p < 75) return TOK_TRAILING;
      if (p < 90) return TOK_NOISE;
      return TOK_SIGNS;
   endfunction

   task automatic test_sign_handling();
      put_text("-");
      send_token(6'd10);
      put_text("+");
      send_token(6'd10);
      put_text("+x");
      send_token(6'd16);
      put_text("-101");
      send_token(6'd2);
      put_text("+Zz");
      send_token(6'd36);
   endtask

   task automatic test_field_extremes();
      token_chars.push_back(8'h00);
      send_token(6'd2);
      token_chars.push_back(8'hFF);
      send_token(6'd36);
      put_text("19");
      send_token(6'd9);
      put_text("1");
      send_token(6'd2);
   endtask

   task automatic test_underscore_skip();
      put_text("1_0");
      send_token(6'd10);
      set_underscore_skip(1'b1);
      put_text("_1_0");
      send_token(6'd10);
   endtask

   task automatic test_random_tokens(input int n_items);
      int stop_at;
      int count;
      logic [BASE_W-1:0] b;
      sign_kind_type s;
      logic [VALUE_W-1:0] m;
      stop_at = chars_sent + n_items;
      count = 0;
      while (chars_sent < stop_at) begin
         b = $urandom_range(2, 36);
         s = sign_kind_type'($urandom_range(0, 2));
         case (pick_kind())
            TOK_NUMBER: begin
               put_sign(s);
               put_digits(b, ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                          : $urandom_range(1, 6));
            end
            TOK_NEAR_LIMIT: begin
               put_sign(s);
               m = (s == SIGN_MINUS) ? LIMIT_NEG : LIMIT_POS;
               case ($urandom_range(0, 4))
                  1: m = m + 64'd1;
                  2: m = m - 64'($urandom_range(1, 1000));
                  3: m = m + 64'($urandom_range(2, 1000));
                  4: m = {$urandom, $urandom} >> $urandom_range(0, 40);
                  default: m = m;
               endcase
               if ($urandom_range(0, 3) == 0) token_chars.push_back(CH_DIGIT_LO);
               put_magnitude(m, b);
               if ($urandom_range(0, 5) == 0) put_digits(b, 1);
            end
            TOK_TRAILING: begin
               put_sign(s);
               put_digits(b, $urandom_range(1, 5));
               put_non_digit(b);
               repeat ($urandom_range(0, 4)) token_chars.push_back(8'($urandom_range(0, 255)));
            end
            TOK_NOISE: begin
               repeat ($urandom_range(1, 6)) token_chars.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
               put_sign(s == SIGN_NONE ? SIGN_MINUS : s);
               case ($urandom_range(0, 2))
                  1: put_non_digit(b);
                  2: begin
                     put_sign(sign_kind_type'($urandom_range(1, 2)));
                     put_digits(b, $urandom_range(1, 3));
                  end
                  default: ;
               endcase
            end
         endcase
         send_token(b);
         count++;
         if (count % 37 == 0) drain_results();
      end
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(16, 80);
      end
      rx_left--;
      case (rx_mode)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_CHOPPY: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: value %0d ok %0b", rsp_value, rsp_ok);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_value !== want.value || rsp_ok !== want.ok) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch on result %0d: expected value %0d ok %0b, got value %0d ok %0b",
                           results_checked, want.value, want.ok, rsp_value, rsp_ok);
            end
         end
      end
   end

   // watchdog on handshake activity
   initial begin
      int stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("no handshake for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, pending_results.size());
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_underscore_skip(1'b0);
      test_sign_handling();
      test_field_extremes();
      test_underscore_skip();
      test_random_tokens(320);
      set_underscore_skip(1'b0);
      test_random_tokens(320);
      drain_results();
      $display("sent %0d characters in %0d tokens, radix 2 to 36, underscore skip on and off",
               chars_sent, tokens_sent);
      $display("checked %0d results: %0d rejected, %0d negative, %0d failures",
               results_checked, rejected_count, negative_count, fail_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
